// ===== design/vcrw_pkg.sv =====
`default_nettype none
package vcrw_pkg;

  localparam int unsigned CNT_W  = 12;
  localparam int unsigned PIX_W  = 8;
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned IDX_W  = 2;
  localparam int unsigned FILL_W = 2;
  localparam int unsigned PACK_W = 24;

  // command queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = 2;
  localparam int unsigned QCW    = 3;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_BASE   = 2'd2;
  localparam logic [IDX_W-1:0] REG_SIZE   = 2'd3;

  localparam logic [CNT_W-1:0]  WIDTH_RST  = 12'd640;
  localparam logic [CNT_W-1:0]  HEIGHT_RST = 12'd480;
  localparam logic [ADDR_W-1:0] BASE_RST   = 32'd0;
  localparam logic [ADDR_W-1:0] SIZE_RST   = 32'd307200;

  // result codes
  localparam logic [KIND_W-1:0] EV_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] EV_DROP  = 2'd1;
  localparam logic [KIND_W-1:0] EV_SHORT = 2'd2;

  // queue command codes
  localparam logic [KIND_W-1:0] CMD_PIXEL = 2'd0;
  localparam logic [KIND_W-1:0] CMD_DROP  = 2'd1;
  localparam logic [KIND_W-1:0] CMD_SHORT = 2'd2;

  localparam logic [FILL_W-1:0] FILL_LAST = 2'd3;
  localparam logic [ADDR_W:0]   WORD_STEP = 33'd4;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [PIX_W-1:0]  px;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] width;
    logic [CNT_W-1:0] height;
  } geom_t;

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] size;
  } buf_t;

endpackage
`default_nettype wire

// ===== design/vcrw_pix_if.sv =====
`default_nettype none
interface vcrw_pix_if;
  logic                     valid;
  logic                     ready;
  logic                     frame_active;
  logic                     line_active;
  logic [vcrw_pkg::PIX_W-1:0] pixel_byte;

  modport source (output valid, frame_active, line_active, pixel_byte, input ready);
  modport sink   (input valid, frame_active, line_active, pixel_byte, output ready);
endinterface
`default_nettype wire

// ===== design/vcrw_evt_if.sv =====
`default_nettype none
interface vcrw_evt_if;
  logic                        valid;
  logic                        ready;
  logic [vcrw_pkg::KIND_W-1:0] event_kind;
  logic [vcrw_pkg::ADDR_W-1:0] write_address;
  logic [vcrw_pkg::WORD_W-1:0] write_word;
  logic                        first_write;

  modport source (output valid, event_kind, write_address, write_word, first_write,
                  input ready);
  modport sink   (input valid, event_kind, write_address, write_word, first_write,
                  output ready);
endinterface
`default_nettype wire

// ===== design/vcrw_fifo.sv =====
`default_nettype none
module vcrw_fifo (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  vcrw_pkg::cmd_t      push_data_i,
  output logic                full_o,
  input  wire                 pop_i,
  output vcrw_pkg::cmd_t      pop_data_o,
  output logic                empty_o
);

  vcrw_pkg::cmd_t                mem_q [vcrw_pkg::QDEPTH];
  logic [vcrw_pkg::QAW-1:0]      wr_q, wr_d;
  logic [vcrw_pkg::QAW-1:0]      rd_q, rd_d;
  logic [vcrw_pkg::QCW-1:0]      cnt_q, cnt_d;

  assign full_o     = (cnt_q == vcrw_pkg::QCW'(vcrw_pkg::QDEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && !pop_i |-> !push_i)
    else $error("command queue overflow");

endmodule
`default_nettype wire

// ===== design/vcrw_front.sv =====
`default_nettype none
module vcrw_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  vcrw_pkg::geom_t     geom_i,
  vcrw_pix_if.sink            pix,
  input  wire                 full_i,
  output logic                push_o,
  output vcrw_pkg::cmd_t      cmd_o
);

  logic [vcrw_pkg::CNT_W-1:0] col_q, col_d;
  logic [vcrw_pkg::CNT_W-1:0] line_q, line_d;
  logic                       take;

  assign pix.ready = !full_i;
  assign take      = pix.valid && !full_i;

  always_comb begin
    col_d      = col_q;
    line_d     = line_q;
    push_o     = 1'b0;
    cmd_o.kind = vcrw_pkg::CMD_PIXEL;
    cmd_o.px   = pix.pixel_byte;
    if (take) begin
      if (pix.frame_active && pix.line_active) begin
        push_o = 1'b1;
        if (col_q < geom_i.width && line_q < geom_i.height) begin
          col_d = col_q + 1'b1;
        end else begin
          cmd_o.kind = vcrw_pkg::CMD_DROP;
        end
      end else if (pix.frame_active) begin
        // hblank: close a complete line, flag a partial one
        if (col_q == geom_i.width) begin
          col_d  = '0;
          line_d = line_q + 1'b1;
        end else if (col_q != '0) begin
          push_o     = 1'b1;
          cmd_o.kind = vcrw_pkg::CMD_SHORT;
        end
      end else if (col_q == geom_i.width && line_q == geom_i.height - 1'b1) begin
        col_d  = '0;
        line_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      line_q <= '0;
    end else begin
      col_q  <= col_d;
      line_q <= line_d;
    end
  end

  a_drop_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && cmd_o.kind == vcrw_pkg::CMD_DROP |=> $stable(col_q) && $stable(line_q))
    else $error("dropped pixel moved the counters");

endmodule
`default_nettype wire

// ===== design/vcrw_back.sv =====
`default_nettype none
module vcrw_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  vcrw_pkg::buf_t      buf_i,
  input  wire                 empty_i,
  input  vcrw_pkg::cmd_t      cmd_i,
  output logic                pop_o,
  vcrw_evt_if.source          evt
);

  logic [vcrw_pkg::PACK_W-1:0] pack_q, pack_d;
  logic [vcrw_pkg::FILL_W-1:0] fill_q, fill_d;
  logic [vcrw_pkg::ADDR_W-1:0] off_q, off_d;
  logic                        started_q, started_d;
  logic                        vld_q, vld_d;
  logic [vcrw_pkg::KIND_W-1:0] kind_q, kind_d;
  logic [vcrw_pkg::ADDR_W-1:0] addr_q, addr_d;
  logic [vcrw_pkg::WORD_W-1:0] word_q, word_d;
  logic                        first_q, first_d;
  logic                        res;
  logic [vcrw_pkg::ADDR_W:0]   off_next;

  assign pop_o    = !empty_i && (!vld_q || evt.ready);
  assign off_next = {1'b0, off_q} + vcrw_pkg::WORD_STEP;

  always_comb begin
    pack_d    = pack_q;
    fill_d    = fill_q;
    off_d     = off_q;
    started_d = started_q;
    res       = 1'b0;
    kind_d    = vcrw_pkg::EV_WRITE;
    addr_d    = '0;
    word_d    = '0;
    first_d   = 1'b0;
    if (pop_o) begin
      case (cmd_i.kind)
        vcrw_pkg::CMD_PIXEL: begin
          if (fill_q != vcrw_pkg::FILL_LAST) begin
            case (fill_q)
              2'd0:    pack_d[7:0]   = cmd_i.px;
              2'd1:    pack_d[15:8]  = cmd_i.px;
              default: pack_d[23:16] = cmd_i.px;
            endcase
            fill_d = fill_q + 1'b1;
          end else begin
            res       = 1'b1;
            kind_d    = vcrw_pkg::EV_WRITE;
            addr_d    = buf_i.base + off_q;
            word_d    = {cmd_i.px, pack_q};
            first_d   = !started_q;
            started_d = 1'b1;
            pack_d    = '0;
            fill_d    = '0;
            // wrap compare done at 33 bits so a size near 2^32 still works
            off_d     = (off_next >= {1'b0, buf_i.size}) ? '0
                                                        : off_next[vcrw_pkg::ADDR_W-1:0];
          end
        end
        vcrw_pkg::CMD_DROP: begin
          res    = 1'b1;
          kind_d = vcrw_pkg::EV_DROP;
        end
        vcrw_pkg::CMD_SHORT: begin
          res    = 1'b1;
          kind_d = vcrw_pkg::EV_SHORT;
        end
        default: begin
          res = 1'b0;
        end
      endcase
    end
    vld_d = res ? 1'b1 : (evt.ready ? 1'b0 : vld_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pack_q    <= '0;
      fill_q    <= '0;
      off_q     <= '0;
      started_q <= 1'b0;
      vld_q     <= 1'b0;
    end else begin
      pack_q    <= pack_d;
      fill_q    <= fill_d;
      off_q     <= off_d;
      started_q <= started_d;
      vld_q     <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res) begin
      kind_q  <= kind_d;
      addr_q  <= addr_d;
      word_q  <= word_d;
      first_q <= first_d;
    end
  end

  assign evt.valid         = vld_q;
  assign evt.event_kind    = kind_q;
  assign evt.write_address = addr_q;
  assign evt.write_word    = word_q;
  assign evt.first_write   = first_q;

  a_offset_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    off_q[1:0] == 2'b00)
    else $error("write offset lost word alignment");

  a_word_clears_pack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && cmd_i.kind == vcrw_pkg::CMD_PIXEL && fill_q == vcrw_pkg::FILL_LAST
    |=> fill_q == '0 && started_q && vld_q)
    else $error("word write did not restart packing");

  a_first_only_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q && first_q |-> kind_q == vcrw_pkg::EV_WRITE)
    else $error("first_write on a non-write result");

endmodule
`default_nettype wire

// ===== design/video_capture_to_ram_writer.sv =====
// Path: pixel -> command queue -> packer -> registered event output.
// Throughput: one pixel byte per cycle while the queue is not full; a 4-entry command
// queue lets the pixel counters and the packer/address unit stall apart, and the
// output register holds one result while the next input is taken.
// Reset (rst_ni, async low): counters, packer, offset and queue cleared; config regs
// return to 640 x 480, base 0, size 307200.
`default_nettype none
module video_capture_to_ram_writer (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  vcrw_pix_if.sink                      in_chan,
  vcrw_evt_if.source                    out_chan,
  input  wire                           cfg_we_i,
  input  wire [vcrw_pkg::IDX_W-1:0]     cfg_idx_i,
  input  wire [vcrw_pkg::ADDR_W-1:0]    cfg_data_i
);

  vcrw_pkg::geom_t geom_q;
  vcrw_pkg::buf_t  buf_q;
  vcrw_pkg::cmd_t  push_cmd;
  vcrw_pkg::cmd_t  pop_cmd;
  logic            push;
  logic            pop;
  logic            full;
  logic            empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      geom_q.width  <= vcrw_pkg::WIDTH_RST;
      geom_q.height <= vcrw_pkg::HEIGHT_RST;
      buf_q.base    <= vcrw_pkg::BASE_RST;
      buf_q.size    <= vcrw_pkg::SIZE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        vcrw_pkg::REG_WIDTH:  geom_q.width  <= cfg_data_i[vcrw_pkg::CNT_W-1:0];
        vcrw_pkg::REG_HEIGHT: geom_q.height <= cfg_data_i[vcrw_pkg::CNT_W-1:0];
        vcrw_pkg::REG_BASE:   buf_q.base    <= cfg_data_i;
        vcrw_pkg::REG_SIZE:   buf_q.size    <= cfg_data_i;
        default: begin
          buf_q <= buf_q;
        end
      endcase
    end
  end

  vcrw_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .geom_i (geom_q),
    .pix    (in_chan),
    .full_i (full),
    .push_o (push),
    .cmd_o  (push_cmd)
  );

  vcrw_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_cmd),
    .empty_o     (empty)
  );

  vcrw_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .buf_i   (buf_q),
    .empty_i (empty),
    .cmd_i   (pop_cmd),
    .pop_o   (pop),
    .evt     (out_chan)
  );

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned MAX_PRINTS   = 100;

  typedef struct packed {
    logic [vcrw_pkg::KIND_W-1:0] kind;
    logic [vcrw_pkg::ADDR_W-1:0] addr;
    logic [vcrw_pkg::WORD_W-1:0] word;
    logic                        first;
  } capture_evt_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic [vcrw_pkg::IDX_W-1:0]  cfg_idx_i;
  logic [vcrw_pkg::ADDR_W-1:0] cfg_data_i;

  vcrw_pix_if pix_if ();
  vcrw_evt_if evt_if ();

  video_capture_to_ram_writer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_chan    (pix_if.sink),
    .out_chan   (evt_if.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // predictor copy of the registers and of the capture state
  logic [vcrw_pkg::CNT_W-1:0]  cap_width, cap_height;
  logic [vcrw_pkg::ADDR_W-1:0] cap_base, cap_size;
  logic [vcrw_pkg::CNT_W-1:0]  col_cnt, line_cnt;
  logic [vcrw_pkg::PACK_W-1:0] pack_bytes;
  logic [vcrw_pkg::FILL_W-1:0] pack_fill;
  logic [vcrw_pkg::ADDR_W-1:0] wr_offset;
  logic                        started;

  capture_evt_t pending_events[$];
  int unsigned  err_count;
  int unsigned  samples_sent;
  int unsigned  sink_stall;
  int unsigned  hold_req;
  int unsigned  hold_left;
  bit           idle_on;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= MAX_PRINTS) $display("%0t: %s", $realtime, msg);
  endtask

  function automatic void predict_capture(input logic fv, input logic lv,
                                          input logic [vcrw_pkg::PIX_W-1:0] px);
    capture_evt_t              ev;
    logic [vcrw_pkg::ADDR_W:0] nxt;
    ev = '0;
    if (fv && lv) begin
      if (col_cnt < cap_width && line_cnt < cap_height) begin
        col_cnt = col_cnt + 1'b1;
        if (pack_fill != vcrw_pkg::FILL_LAST) begin
          pack_bytes = pack_bytes |
                       (vcrw_pkg::PACK_W'(px) << (vcrw_pkg::PIX_W * pack_fill));
          pack_fill  = pack_fill + 1'b1;
        end else begin
          ev.kind  = vcrw_pkg::EV_WRITE;
          ev.addr  = cap_base + wr_offset;
          ev.word  = {px, pack_bytes};
          ev.first = ~started;
          pending_events.push_back(ev);
          started    = 1'b1;
          pack_bytes = '0;
          pack_fill  = '0;
          // wrap test done one bit wider so a size near 2^32 cannot overflow
          nxt = {1'b0, wr_offset} + vcrw_pkg::WORD_STEP;
          if (nxt >= {1'b0, cap_size}) nxt = '0;
          wr_offset = nxt[vcrw_pkg::ADDR_W-1:0];
        end
      end else begin
        ev.kind = vcrw_pkg::EV_DROP;
        pending_events.push_back(ev);
      end
    end else if (fv) begin
      if (col_cnt == cap_width) begin
        col_cnt  = '0;
        line_cnt = line_cnt + 1'b1;
      end else if (col_cnt != '0) begin
        ev.kind = vcrw_pkg::EV_SHORT;
        pending_events.push_back(ev);
      end
    end else if (col_cnt == cap_width && line_cnt == cap_height - 1'b1) begin
      col_cnt  = '0;
      line_cnt = '0;
    end
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic drive_sample(input logic fv, input logic lv,
                              input logic [vcrw_pkg::PIX_W-1:0] px);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pix_if.valid        <= 1'b1;
    pix_if.frame_active <= fv;
    pix_if.line_active  <= lv;
    pix_if.pixel_byte   <= px;
    do @(posedge clk_i); while (!pix_if.ready);
    predict_capture(fv, lv, px);
    samples_sent++;
    @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [vcrw_pkg::IDX_W-1:0] idx,
                           input logic [vcrw_pkg::ADDR_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      vcrw_pkg::REG_WIDTH:  cap_width  = data[vcrw_pkg::CNT_W-1:0];
      vcrw_pkg::REG_HEIGHT: cap_height = data[vcrw_pkg::CNT_W-1:0];
      vcrw_pkg::REG_BASE:   cap_base   = data;
      vcrw_pkg::REG_SIZE:   cap_size   = data;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // upper data bits of the geometry registers are junk on purpose
  task automatic load_config(input logic [vcrw_pkg::CNT_W-1:0] w,
                             input logic [vcrw_pkg::CNT_W-1:0] h,
                             input logic [vcrw_pkg::ADDR_W-1:0] base,
                             input logic [vcrw_pkg::ADDR_W-1:0] size);
    cfg_write(vcrw_pkg::REG_WIDTH, {20'($urandom()), w});
    cfg_write(vcrw_pkg::REG_HEIGHT, {20'($urandom()), h});
    cfg_write(vcrw_pkg::REG_BASE, base);
    cfg_write(vcrw_pkg::REG_SIZE, size);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    pix_if.valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    // pixels still being packed give no event, so let the queue drain
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // walk the counters back to the top of a frame
  task automatic finish_frame();
    while (col_cnt != '0 || line_cnt != '0) begin
      if (col_cnt < cap_width) drive_sample(1'b1, 1'b1, 8'($urandom()));
      else if (line_cnt == cap_height - 1'b1)
        drive_sample(1'b0, 1'($urandom_range(0, 1)), 8'($urandom()));
      else drive_sample(1'b1, 1'b0, 8'($urandom()));
    end
  endtask

  task automatic send_frame();
    int unsigned n;
    finish_frame();
    for (int ln = 0; ln < int'(cap_height); ln++) begin
      for (int c = 0; c < int'(cap_width); c++) begin
        if ($urandom_range(0, 19) == 0)
          drive_sample(1'($urandom_range(0, 1)), 1'b0, 8'($urandom()));
        drive_sample(1'b1, 1'b1, 8'($urandom()));
      end
      if ($urandom_range(0, 9) == 0) drive_sample(1'b1, 1'b1, 8'($urandom()));
      if (ln < int'(cap_height) - 1) begin
        n = $urandom_range(1, 2);
        repeat (n) drive_sample(1'b1, 1'b0, 8'($urandom()));
      end
    end
    n = $urandom_range(1, 3);
    repeat (n) drive_sample(1'b0, 1'($urandom_range(0, 1)), 8'($urandom()));
  endtask

  task automatic send_noise();
    logic fv, lv;
    fv = 1'($urandom_range(0, 1));
    lv = 1'($urandom_range(0, 1));
    // an hblank after the last full line would leave the counters locked
    if (fv && !lv && col_cnt == cap_width && line_cnt == cap_height - 1'b1) fv = 1'b0;
    drive_sample(fv, lv, 8'($urandom()));
  endtask

  task automatic test_reset_defaults();
    repeat (8) drive_sample(1'b1, 1'b1, 8'($urandom()));
    wait_idle();
    load_config(12'd8, 12'd1, 32'h0, vcrw_pkg::SIZE_RST);
    finish_frame();
  endtask

  task automatic test_directed();
    wait_idle();
    load_config(12'd4, 12'd2, 32'hFFFF_FFF8, 32'd8);
    drive_sample(1'b1, 1'b1, 8'h00);
    drive_sample(1'b1, 1'b1, 8'hFF);
    drive_sample(1'b1, 1'b1, 8'h80);
    drive_sample(1'b1, 1'b1, 8'h01);
    drive_sample(1'b0, 1'b0, 8'h00);
    drive_sample(1'b1, 1'b0, 8'h00);
    drive_sample(1'b1, 1'b1, 8'h55);
    drive_sample(1'b1, 1'b1, 8'hAA);
    drive_sample(1'b1, 1'b0, 8'hFF);
    drive_sample(1'b1, 1'b0, 8'h00);
    drive_sample(1'b0, 1'b1, 8'hFF);
    drive_sample(1'b1, 1'b1, 8'h12);
    drive_sample(1'b1, 1'b1, 8'h34);
    drive_sample(1'b1, 1'b1, 8'h77);
    drive_sample(1'b1, 1'b0, 8'h00);
    // line count now equals the height: pixels are dropped
    drive_sample(1'b1, 1'b1, 8'hFE);
    drive_sample(1'b1, 1'b1, 8'h01);
    wait_idle();
    load_config(12'd4, 12'd3, 32'hFFFF_FFFF, 32'd6);
    finish_frame();
  endtask

  task automatic test_backpressure();
    wait_idle();
    load_config(12'd4, 12'd10, $urandom(), 32'h100);
    idle_on = 1'b0;
    @(posedge clk_i);
    hold_req = HOLD_CYCLES;
    @(negedge clk_i);
    send_frame();
    idle_on = 1'b1;
  endtask

  task automatic test_geometry_extremes();
    wait_idle();
    // widest line: run part of it, then shrink the width to close it
    load_config(12'd4095, 12'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFC);
    repeat (24) drive_sample(1'b1, 1'b1, 8'($urandom()));
    drive_sample(1'b1, 1'b0, 8'($urandom()));
    drive_sample(1'b0, 1'b0, 8'($urandom()));
    wait_idle();
    load_config(12'd24, 12'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFC);
    finish_frame();
    wait_idle();
    // tallest frame: a few lines, then shrink the height to close it
    load_config(12'd1, 12'd4095, $urandom(), 32'd4);
    repeat (12) begin
      drive_sample(1'b1, 1'b1, 8'($urandom()));
      drive_sample(1'b1, 1'b0, 8'($urandom()));
    end
    drive_sample(1'b1, 1'b1, 8'($urandom()));
    wait_idle();
    load_config(12'd1, 12'd13, 32'h0, 32'd4);
    finish_frame();
    wait_idle();
    load_config(12'd1, 12'd1, 32'h0, 32'd5);
    send_frame();
    send_frame();
  endtask

  task automatic test_random_frames();
    logic [vcrw_pkg::CNT_W-1:0]  w, h;
    logic [vcrw_pkg::ADDR_W-1:0] base, size;
    int unsigned                 start;
    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      w = ($urandom_range(0, 5) == 0) ? 12'($urandom_range(9, 40)) : 12'($urandom_range(1, 8));
      h = 12'($urandom_range(1, 4));
      case ($urandom_range(0, 3))
        0: size = 32'd4;
        1: size = 32'hFFFF_FFFC;
        2: size = $urandom_range(4, 64);
        default: size = $urandom();
      endcase
      if (size < 32'd4) size = 32'd4;
      case ($urandom_range(0, 2))
        0: base = 32'h0;
        1: base = 32'hFFFF_FFFF;
        default: base = $urandom();
      endcase
      load_config(w, h, base, size);
      idle_on = (ph % 3) != 2;
      start = samples_sent;
      while (samples_sent - start < 90) begin
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 6)) send_noise();
        else send_frame();
      end
      finish_frame();
    end
    idle_on = 1'b1;
  endtask

  always @(posedge clk_i) begin : event_check
    capture_evt_t got, want;
    if (rst_ni && evt_if.valid && evt_if.ready) begin
      got.kind  = evt_if.event_kind;
      got.addr  = evt_if.write_address;
      got.word  = evt_if.write_word;
      got.first = evt_if.first_write;
      if (pending_events.size() == 0) begin
        report_mismatch($sformatf("unexpected event, kind %0d addr %h", got.kind, got.addr));
      end else begin
        want = pending_events.pop_front();
        if (got.kind !== want.kind)
          report_mismatch($sformatf("event_kind %0d, want %0d", got.kind, want.kind));
        if (got.addr !== want.addr)
          report_mismatch($sformatf("write_address %h, want %h", got.addr, want.addr));
        if (got.word !== want.word)
          report_mismatch($sformatf("write_word %h, want %h", got.word, want.word));
        if (got.first !== want.first)
          report_mismatch($sformatf("first_write %b, want %b", got.first, want.first));
      end
      sink_stall = idle_on ? $urandom_range(0, 3) : 0;
    end
  end

  always @(negedge clk_i) begin : sink_pace
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      evt_if.ready <= 1'b0;
    end else if (sink_stall != 0) begin
      sink_stall--;
      evt_if.ready <= 1'b0;
    end else begin
      evt_if.ready <= 1'b1;
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((pix_if.valid && pix_if.ready) || (evt_if.valid && evt_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("tb_top: errors");
    $finish;
  end

  initial begin : main_seq
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = vcrw_pkg::REG_WIDTH;
    cfg_data_i          = '0;
    pix_if.valid        = 1'b0;
    pix_if.frame_active = 1'b0;
    pix_if.line_active  = 1'b0;
    pix_if.pixel_byte   = '0;
    evt_if.ready        = 1'b0;
    cap_width           = vcrw_pkg::WIDTH_RST;
    cap_height          = vcrw_pkg::HEIGHT_RST;
    cap_base            = vcrw_pkg::BASE_RST;
    cap_size            = vcrw_pkg::SIZE_RST;
    col_cnt             = '0;
    line_cnt            = '0;
    pack_bytes          = '0;
    pack_fill           = '0;
    wr_offset           = '0;
    started             = 1'b0;
    err_count           = 0;
    samples_sent        = 0;
    sink_stall          = 0;
    hold_req            = 0;
    hold_left           = 0;
    idle_on             = 1'b1;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_directed();
    test_backpressure();
    test_geometry_extremes();
    test_random_frames();
    wait_idle();

    if (err_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
